FILE: hdl/tile_priority_by_distance_unit_defines.svh
// Assertion macros shared by the tile priority unit.
`ifndef TILE_PRIORITY_BY_DISTANCE_UNIT_DEFINES_SVH
`define TILE_PRIORITY_BY_DISTANCE_UNIT_DEFINES_SVH

// Fire when cond is ever true out of reset.
`define TPD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tpd: forbidden condition seen");

// Fire when pre holds and post does not follow.
`define TPD_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> post) \
    else $error("tpd: implication violated");

`endif

FILE: hdl/tpd_pkg.sv
// Shared constants and types for the tile priority unit.
package tpd_pkg;
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int DPI_W      = 8;
  localparam int GAP_W      = COORD_BITS + 2;
  localparam int ROOT_W     = FRAC_BITS + 8;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int DVS_W      = ROOT_W + 1;
  localparam int DIV_W      = ROOT_W + 2;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int LATENCY    = ROOT_W + FRAC_BITS + 7;

  localparam logic [Q_W-1:0]   ONE         = Q_W'(1) << FRAC_BITS;
  localparam logic [DPI_W-1:0] DPI_MIN     = 8'd72;
  localparam logic [DPI_W-1:0] DPI_MAX     = 8'd250;
  localparam logic [DPI_W-1:0] DPI_RESET   = 8'd90;
  localparam logic [DPI_W-1:0] DPI_HIGH    = 8'd144;
  localparam logic [GAP_W-1:0] HALF_BIG    = GAP_W'(256);
  localparam logic [GAP_W-1:0] HALF_SMALL  = GAP_W'(128);
  localparam logic [DIV_W-1:0] DIV_SEED    = DIV_W'(128);
  localparam logic [DVS_W-1:0] DVS_OFFSET  = DVS_W'(256);

  typedef struct packed {
    logic                 zero;
    logic [FRAC_BITS-1:0] dx;
    logic [FRAC_BITS-1:0] dy;
  } job_t;
endpackage

FILE: hdl/tile_priority_by_distance_unit.sv
// Path to the result strobe: front register, queue, squares, root and reciprocal pipelines.
// Throughput: one request per cycle; busy never rises, the back end drains the queue each cycle.
// The root takes one stage per result bit, the reciprocal one stage per quotient bit.
// Reset (rst_n low, synchronous) empties all stages and sets the DPI register (dpi_r) to 90.
// Results cannot be stalled: each appears for one cycle with out_valid.
module tile_priority_by_distance_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_tile_left,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_tile_top,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_view_left,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_view_top,
  input  logic [15:0]                    in_view_width,
  input  logic [15:0]                    in_view_height,
  input  logic                           cfg_we,
  input  logic [tpd_pkg::DPI_W-1:0]      cfg_data,
  output logic                           out_valid,
  output logic [tpd_pkg::Q_W-1:0]        out_priority_res
);
  import tpd_pkg::*;
  `include "tile_priority_by_distance_unit_defines.svh"

  logic accept, f_valid, full, h_valid;
  job_t f_job, h_job;

  assign accept = start && !busy;
  assign busy   = full;

  tpd_front u_front (
    .clk, .rst_n, .accept,
    .in_tile_left, .in_tile_top, .in_view_left, .in_view_top,
    .in_view_width, .in_view_height,
    .cfg_we, .cfg_data,
    .job_valid (f_valid),
    .job       (f_job)
  );

  tpd_queue u_queue (
    .clk, .rst_n,
    .push       (f_valid),
    .push_job   (f_job),
    .full,
    .head_valid (h_valid),
    .head_job   (h_job)
  );

  tpd_back u_back (
    .clk, .rst_n,
    .job_valid (h_valid),
    .job       (h_job),
    .out_valid,
    .out_priority_res
  );

  `TPD_ASSERT_IMPL(a_no_orphan, out_valid, $past(accept, LATENCY))
  `TPD_ASSERT_IMPL(a_delivered, accept, ##LATENCY out_valid)
  `TPD_ASSERT_NEVER(a_range, out_valid && (out_priority_res > ONE))
  `TPD_ASSERT_NEVER(a_q_ovf, f_valid && full)
endmodule

FILE: hdl/tpd_front.sv
// Front end: DPI register, tile centre, gaps to the viewport, far test.
module tpd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_tile_left,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_tile_top,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_view_left,
  input  logic [tpd_pkg::COORD_BITS-1:0] in_view_top,
  input  logic [15:0]                    in_view_width,
  input  logic [15:0]                    in_view_height,
  input  logic                           cfg_we,
  input  logic [tpd_pkg::DPI_W-1:0]      cfg_data,
  output logic                           job_valid,
  output tpd_pkg::job_t                  job
);
  import tpd_pkg::*;

  logic [DPI_W-1:0] dpi_r, dpi_nxt;
  logic             valid_r;
  job_t             job_r, job_nxt;
  logic [GAP_W-1:0] half;

  function automatic logic [GAP_W-1:0] sx(input logic [COORD_BITS-1:0] v);
    sx = {{(GAP_W-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic logic [GAP_W-1:0] gap(input logic [GAP_W-1:0] c,
                                           input logic [GAP_W-1:0] lo,
                                           input logic [GAP_W-1:0] hi);
    if ($signed(c) < $signed(lo)) begin
      gap = lo - c;
    end else if ($signed(c) > $signed(hi)) begin
      gap = c - hi;
    end else begin
      gap = '0;
    end
  endfunction

  function automatic logic far(input logic [GAP_W-1:0] g);
    far = {{(64-GAP_W){1'b0}}, g} >= 64'(ONE);
  endfunction

  always_comb begin
    logic [GAP_W-1:0] cx, cy, hx, hy, gx, gy;
    dpi_nxt = dpi_r;
    if (cfg_we) begin
      if (cfg_data < DPI_MIN) begin
        dpi_nxt = DPI_MIN;
      end else if (cfg_data > DPI_MAX) begin
        dpi_nxt = DPI_MAX;
      end else begin
        dpi_nxt = cfg_data;
      end
    end
    half = (dpi_r > DPI_HIGH) ? HALF_BIG : HALF_SMALL;
    cx = sx(in_tile_left) + half;
    cy = sx(in_tile_top) + half;
    hx = sx(in_view_left) + GAP_W'(in_view_width);
    hy = sx(in_view_top) + GAP_W'(in_view_height);
    gx = gap(cx, sx(in_view_left), hx);
    gy = gap(cy, sx(in_view_top), hy);
    job_nxt.zero = far(gx) || far(gy);
    job_nxt.dx   = FRAC_BITS'(gx);
    job_nxt.dy   = FRAC_BITS'(gy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpi_r   <= DPI_RESET;
      valid_r <= 1'b0;
    end else begin
      dpi_r   <= dpi_nxt;
      valid_r <= accept;
    end
    job_r <= job_nxt;
  end

  assign job_valid = valid_r;
  assign job       = job_r;
endmodule

FILE: hdl/tpd_queue.sv
// Two-entry request queue between front and back end.
module tpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpd_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output tpd_pkg::job_t head_job
);
  import tpd_pkg::*;

  job_t       mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop        = cnt_r != 2'd0;
  assign full       = cnt_r == 2'd2;
  assign head_valid = pop;
  assign head_job   = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
    end
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end
endmodule

FILE: hdl/tpd_back.sv
// Back end: squares, pipelined integer root and pipelined reciprocal.
module tpd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_valid,
  input  tpd_pkg::job_t             job,
  output logic                      out_valid,
  output logic [tpd_pkg::Q_W-1:0]   out_priority_res
);
  import tpd_pkg::*;

  logic                   a_v_r, a_zero_r;
  logic [2*FRAC_BITS-1:0] a_dx2_r, a_dy2_r;

  logic             s_v_r    [ROOT_W+1];
  logic             s_zero_r [ROOT_W+1];
  logic [RAD_W-1:0] s_rad_r  [ROOT_W+1];
  logic [ROOT_W:0]  s_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] s_root_r [ROOT_W+1];

  logic             d_v_r, d_zero_r;
  logic [DVS_W-1:0] d_dvs_r;

  logic             q_v_r    [Q_W+1];
  logic             q_zero_r [Q_W+1];
  logic [DVS_W-1:0] q_dvs_r  [Q_W+1];
  logic [DIV_W-1:0] q_rem_r  [Q_W+1];
  logic [Q_W-1:0]   q_q_r    [Q_W+1];

  logic [2*FRAC_BITS:0] sum;
  assign sum = {1'b0, a_dx2_r} + {1'b0, a_dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      s_v_r[0] <= 1'b0;
      d_v_r    <= 1'b0;
      q_v_r[0] <= 1'b0;
    end else begin
      a_v_r    <= job_valid;
      s_v_r[0] <= a_v_r;
      d_v_r    <= s_v_r[ROOT_W];
      q_v_r[0] <= d_v_r;
    end
    a_zero_r    <= job.zero;
    a_dx2_r     <= job.dx * job.dx;
    a_dy2_r     <= job.dy * job.dy;
    s_zero_r[0] <= a_zero_r || sum[2*FRAC_BITS];
    s_rad_r[0]  <= {sum[2*FRAC_BITS-1:0], 16'd0};
    s_rem_r[0]  <= '0;
    s_root_r[0] <= '0;
    d_zero_r    <= s_zero_r[ROOT_W];
    d_dvs_r     <= {1'b0, s_root_r[ROOT_W]} + DVS_OFFSET;
    q_zero_r[0] <= d_zero_r;
    q_dvs_r[0]  <= d_dvs_r;
    q_rem_r[0]  <= DIV_SEED;
    q_q_r[0]    <= '0;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    logic [ROOT_W+2:0] rem_sh, trial;
    logic              ge;
    assign rem_sh = {s_rem_r[i], s_rad_r[i][RAD_W-1 -: 2]};
    assign trial  = {1'b0, s_root_r[i], 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[i+1] <= 1'b0;
      end else begin
        s_v_r[i+1] <= s_v_r[i];
      end
      s_zero_r[i+1] <= s_zero_r[i];
      s_rad_r[i+1]  <= s_rad_r[i] << 2;
      s_rem_r[i+1]  <= ge ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
      s_root_r[i+1] <= {s_root_r[i][ROOT_W-2:0], ge};
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [DIV_W-1:0] rs, dv;
    logic             ge;
    assign rs = {q_rem_r[j][DIV_W-2:0], 1'b0};
    assign dv = {1'b0, q_dvs_r[j]};
    assign ge = rs >= dv;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_v_r[j+1] <= 1'b0;
      end else begin
        q_v_r[j+1] <= q_v_r[j];
      end
      q_zero_r[j+1] <= q_zero_r[j];
      q_dvs_r[j+1]  <= q_dvs_r[j];
      q_rem_r[j+1]  <= ge ? rs - dv : rs;
      q_q_r[j+1]    <= {q_q_r[j][Q_W-2:0], ge};
    end
  end

  assign out_valid        = q_v_r[Q_W];
  assign out_priority_res = q_zero_r[Q_W] ? '0 : q_q_r[Q_W];
endmodule
